FILE: sv/pcg_pkg.sv
// Package for the PCG RXS-M-XS random-number block.
// Holds the word width, the generator and permutation constants and the request kinds.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package pcg_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int KIND_W    = 2;
    localparam int FRAC_BITS = 53;
    localparam int FRAC_SHIFT = WORD_W - FRAC_BITS;
    localparam int PERM_SHIFT = 43;
    localparam int ROT_TOP    = 59;

    localparam logic [WORD_W-1:0] LCG_MULT  = 64'd6364136223846793005;
    localparam logic [WORD_W-1:0] LCG_INC   = 64'd1442695040888963407;
    localparam logic [WORD_W-1:0] PERM_MULT = 64'd12605985483714917081;
    localparam logic [WORD_W-1:0] SEED_RESET = 64'd1;

    localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAC  = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

    // Launch of the shared multiplier: operands are captured on start.
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    // Launch of the remainder unit.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

endpackage

`default_nettype wire

FILE: sv/pcg_req_if.sv
// Request channel of the PCG block: kind and inclusive range bounds.
// Depends on pcg_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface pcg_req_if;
    logic                       valid;
    logic                       ready;
    logic [pcg_pkg::KIND_W-1:0] kind;
    pcg_pkg::word_t             range_min;
    pcg_pkg::word_t             range_max;

    modport source (output valid, output kind, output range_min, output range_max,
                    input ready);
    modport sink   (input valid, input kind, input range_min, input range_max,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/pcg_rsp_if.sv
// Result channel of the PCG block: one 64-bit value per request.
// Depends on pcg_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface pcg_rsp_if;
    logic           valid;
    logic           ready;
    pcg_pkg::word_t random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

FILE: sv/pcg_mul.sv
// Shared 64 x 64 multiplier returning the low 64 bits of the product.
// Uses one 32 x 32 multiplier over three partial products; depends on pcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcg_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcg_pkg::mul_req_t req,
    output logic                   done,
    output pcg_pkg::word_t         product
);

    logic [1:0]                  step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    pcg_pkg::word_t              a_reg;
    pcg_pkg::word_t              b_reg;
    pcg_pkg::word_t              prod_reg;
    pcg_pkg::word_t              acc_reg;
    logic [pcg_pkg::HALF_W-1:0]  op_x;
    logic [pcg_pkg::HALF_W-1:0]  op_y;
    pcg_pkg::word_t              prod_next;
    pcg_pkg::word_t              shifted_prod;

    // Step 0 forms lo*lo, step 1 lo*hi, step 2 hi*lo; the hi*hi term falls off the top.
    always_comb
    begin
        op_x = (step_reg == 2'd2) ? a_reg[pcg_pkg::WORD_W-1:pcg_pkg::HALF_W]
                                  : a_reg[pcg_pkg::HALF_W-1:0];
        op_y = (step_reg == 2'd1) ? b_reg[pcg_pkg::WORD_W-1:pcg_pkg::HALF_W]
                                  : b_reg[pcg_pkg::HALF_W-1:0];
        prod_next    = pcg_pkg::word_t'(op_x) * pcg_pkg::word_t'(op_y);
        shifted_prod = {prod_reg[pcg_pkg::HALF_W-1:0], {pcg_pkg::HALF_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
            if (step_reg == 2'd1)
            begin
                acc_reg <= prod_reg;
            end
            else if (step_reg != 2'd0)
            begin
                acc_reg <= acc_reg + shifted_prod;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

FILE: sv/pcg_div.sv
// Restoring remainder unit: one dividend bit per cycle while busy.
// Only the remainder is kept; depends on pcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcg_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcg_pkg::div_req_t req,
    output logic                   done,
    output pcg_pkg::word_t         remainder
);

    localparam int CNT_W = $clog2(pcg_pkg::WORD_W);

    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    pcg_pkg::word_t          dvd_reg;
    pcg_pkg::word_t          dsr_reg;
    pcg_pkg::word_t          rem_reg;
    logic [pcg_pkg::WORD_W:0] trial;
    logic [pcg_pkg::WORD_W:0] diff;
    pcg_pkg::word_t          rem_next;

    // The partial remainder stays below the divisor, so one extra bit covers the shift.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[pcg_pkg::WORD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = (trial >= {1'b0, dsr_reg}) ? diff[pcg_pkg::WORD_W-1:0]
                                              : trial[pcg_pkg::WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(pcg_pkg::WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[pcg_pkg::WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: sv/pcg_rxs_m_xs_bounded_random.sv
// Top level of the PCG RXS-M-XS generator with bounded and fractional draws.
// Depends on pcg_pkg, pcg_req_if, pcg_rsp_if, pcg_mul and pcg_div.
//
//   Channel   Direction  Contents
//   req       in         kind, range_min, range_max (valid/ready)
//   rsp       out        random_value (valid/ready)
//   cfg       in         cfg_we, cfg_wdata: seed write, loads the generator state
//
// A raw or fractional request takes two passes of the shared multiplier plus sequencing.
// A bounded request over less than the full range adds a pass of the bit-serial
// remainder unit per attempt and repeats the whole draw on rejection.
// Reset loads the state with 1. The block takes one request at a time; a finished result
// sits in the output register, so a new request is taken while it awaits transfer.
`timescale 1ns / 1ps
`default_nettype none

module pcg_rxs_m_xs_bounded_random (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire pcg_pkg::word_t cfg_wdata,
    pcg_req_if.sink             req,
    pcg_rsp_if.source           rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LCG  = 3'd1;
    localparam logic [2:0] S_PERM = 3'd2;
    localparam logic [2:0] S_MIX  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                 state_reg,  state_next;
    pcg_pkg::word_t             gen_reg,    gen_next;
    logic                       out_valid_reg, out_valid_next;
    pcg_pkg::word_t             out_value_reg, out_value_next;
    logic [pcg_pkg::KIND_W-1:0] kind_reg,   kind_next;
    pcg_pkg::word_t             min_reg,    min_next;
    pcg_pkg::word_t             span_reg,   span_next;
    pcg_pkg::word_t             lim_reg,    lim_next;
    pcg_pkg::word_t             draw_reg,   draw_next;
    pcg_pkg::word_t             rem_reg,    rem_next;
    pcg_pkg::word_t             res_reg,    res_next;

    pcg_pkg::mul_req_t          mul_req;
    logic                       mul_done;
    pcg_pkg::word_t             mul_product;
    pcg_pkg::div_req_t          div_req;
    logic                       div_done;
    pcg_pkg::word_t             div_rem;

    logic [5:0]                 rot;
    pcg_pkg::word_t             mix_x;
    pcg_pkg::word_t             perm_out;
    pcg_pkg::word_t             span_in;

    pcg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    pcg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_rem)
    );

    // The xorshift amount is the top five state bits plus five, so 5 to 36.
    always_comb
    begin
        rot      = {1'b0, gen_reg[pcg_pkg::WORD_W-1:pcg_pkg::ROT_TOP]} + 6'd5;
        mix_x    = (gen_reg >> rot) ^ gen_reg;
        perm_out = (mul_product >> pcg_pkg::PERM_SHIFT) ^ mul_product;
        span_in  = req.range_max - req.range_min + pcg_pkg::word_t'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        kind_next      = kind_reg;
        min_next       = min_reg;
        span_next      = span_reg;
        lim_next       = lim_reg;
        draw_next      = draw_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        mul_req.start  = 1'b0;
        mul_req.a      = gen_reg;
        mul_req.b      = pcg_pkg::LCG_MULT;
        div_req.start    = 1'b0;
        div_req.dividend = perm_out;
        div_req.divisor  = span_reg;

        if (cfg_we)
        begin
            gen_next = cfg_wdata;
        end
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next     = req.kind;
                    min_next      = req.range_min;
                    span_next     = span_in;
                    lim_next      = '0 - span_in;
                    mul_req.start = 1'b1;
                    state_next    = S_LCG;
                end
            end
            S_LCG:
            begin
                if (mul_done)
                begin
                    gen_next   = mul_product + pcg_pkg::LCG_INC;
                    state_next = S_PERM;
                end
            end
            S_PERM:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = mix_x;
                mul_req.b     = pcg_pkg::PERM_MULT;
                state_next    = S_MIX;
            end
            S_MIX:
            begin
                if (mul_done)
                begin
                    draw_next = perm_out;
                    if ((kind_reg == pcg_pkg::KIND_RANGE) && (span_reg != '0))
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        res_next   = (kind_reg == pcg_pkg::KIND_FRAC)
                                   ? (perm_out >> pcg_pkg::FRAC_SHIFT) : perm_out;
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rem_next   = div_rem;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                // A draw from the incomplete top interval is biased, so draw again.
                if ((draw_reg - rem_reg) > lim_reg)
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_LCG;
                end
                else
                begin
                    res_next   = min_reg + rem_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= pcg_pkg::SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        kind_reg      <= kind_next;
        min_reg       <= min_next;
        span_reg      <= span_next;
        lim_reg       <= lim_next;
        draw_reg      <= draw_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_value_reg;

`ifndef SYNTHESIS
    a_accept_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_LCG)
        else $error("accepted request did not start the generator step");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and remainder unit finished together");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("remainder unit finished outside its wait state");

    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHK |-> rem_reg < span_reg)
        else $error("remainder not below the span");
`endif

endmodule

`default_nettype wire
